/* design/tmv_pkg.sv */
// Shared types and constants for the triple-modular message voter.
// No dependencies; imported by every module of the voter.
package tmv_pkg;

  localparam int CHANNELS  = 8;
  localparam int MSG_BYTES = 8;
  localparam int REPLICAS  = 3;
  localparam int CH_W      = 3;
  localparam int QDEPTH    = 2;

  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_FWD   = 2'd1;
  localparam logic [1:0] KIND_ALERT = 2'd2;

  typedef struct packed {
    logic [1:0]  replica;
    logic [2:0]  channel;
    logic [63:0] word;
    logic [3:0]  bytes;
  } item_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [63:0] word;
    logic [3:0]  bytes;
    logic [1:0]  kind;
    logic        mismatch;
    logic        restart_valid;
    logic [1:0]  restart_replica;
    logic        last;
  } result_t;

  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len) m[i*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

/* design/tmr_message_voter.sv */
// Top level of the triple-modular message voter.
// Instantiates tmv_front and tmv_back; uses tmv_pkg.
//
// Words from replicas enter a two-entry queue and are worked one at a time by
// a sequencer that pops, forwards, stores and votes; an older pending word
// goes out before the vote, and a restart first copies the agreeing pair member
// into the dissenter, then walks the channels. Results leave through a
// single output register, so a stalled output holds the sequencer only when
// it has another result to send.
module tmr_message_voter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  source_replica,
  input  logic [2:0]  channel,
  input  logic [63:0] message_word,
  input  logic [3:0]  message_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_channel,
  output logic [63:0] out_word,
  output logic [3:0]  out_bytes,
  output logic [1:0]  out_kind,
  output logic        mismatch,
  output logic        restart_valid,
  output logic [1:0]  restart_replica,
  output logic        last
);
  import tmv_pkg::*;

  logic [1:0] replica_mode, nact;
  item_t      in_item, q_item;
  result_t    res;
  logic       q_valid, q_pop;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) replica_mode <= 2'd3;
    else if (cfg_we) replica_mode <= cfg_data;
  end

  assign nact = (replica_mode == 2'd0) ? 2'd1 :
                (32'(replica_mode) > REPLICAS) ? 2'(REPLICAS) : replica_mode;

  assign in_item = '{replica: source_replica, channel: channel,
                     word: message_word, bytes: message_bytes};

  tmv_front u_front (
    .clk, .rst, .nact, .valid(in_valid), .ready(in_ready), .in_item,
    .q_valid, .q_pop, .q_item
  );

  tmv_back u_back (
    .clk, .rst, .nact, .q_valid, .q_pop, .q_item,
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_channel     = res.channel;
  assign out_word        = res.word;
  assign out_bytes       = res.bytes;
  assign out_kind        = res.kind;
  assign mismatch        = res.mismatch;
  assign restart_valid   = res.restart_valid;
  assign restart_replica = res.restart_replica;
  assign last            = res.last;
endmodule

/* design/tmv_front.sv */
// Front end of the voter: accepts input words, drops invalid ones, clamps
// the length and pushes classified items into a two-entry queue. Uses tmv_pkg.
module tmv_front (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     nact,
  input  logic           valid,
  output logic           ready,
  input  tmv_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output tmv_pkg::item_t q_item
);
  import tmv_pkg::*;

  item_t      q [QDEPTH];
  logic       wp, rp;
  logic [1:0] fill;
  logic       keep, push;
  item_t      cl;

  // Classify: clamp the length, mask the word, drop inactive replicas, bad channels and empty words
  always_comb begin
    cl = in_item;
    if (in_item.bytes > 4'(MSG_BYTES)) cl.bytes = 4'(MSG_BYTES);
    cl.word = in_item.word & byte_mask(cl.bytes);
    keep = (in_item.replica < nact) && (32'(in_item.channel) < CHANNELS)
           && (in_item.bytes != 4'd0);
  end

  assign ready   = (fill != 2'(QDEPTH));
  assign push    = valid && ready && keep;
  assign q_valid = (fill != 2'd0);
  assign q_item  = q[rp];

  // Advance queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= cl;
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'(QDEPTH))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 && !push) |=> fill == 2'd0)
    else $error("queue filled without push");
endmodule

/* design/tmv_back.sv */
// Back end of the voter: holds vote counts and stored words, runs the
// forward, vote and restart walk sequencer, and drives one output register.
// Uses tmv_pkg.
module tmv_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       nact,
  input  logic             q_valid,
  output logic             q_pop,
  input  tmv_pkg::item_t   q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output tmv_pkg::result_t out_res
);
  import tmv_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FWD  = 3'd1;
  localparam logic [2:0] S_STORE= 3'd2;
  localparam logic [2:0] S_VOTE = 3'd3;
  localparam logic [2:0] S_COPY = 3'd4;
  localparam logic [2:0] S_WALK = 3'd5;

  logic signed [3:0] cnt [REPLICAS][CHANNELS];
  logic [63:0]       sw  [REPLICAS][CHANNELS];
  logic [3:0]        sl  [REPLICAS][CHANNELS];

  logic [2:0]  state;
  item_t       cur;
  logic [1:0]  pi, pk;
  logic [CH_W-1:0] wch;
  logic        first;
  logic        ch_last;

  // Old word waiting to go out ahead of the vote
  logic        fwd_pend;
  logic [63:0] fwd_word;
  logic [3:0]  fwd_len;

  // Result register and emit helpers
  logic        emit;
  result_t     res;
  logic        can_emit;

  assign q_pop = (state == S_IDLE) && q_valid;
  assign can_emit = !out_valid || out_ready;

  function automatic logic agree_f(input logic [63:0] a, input logic [63:0] b,
                                   input logic [3:0] la);
    return ((a ^ b) & byte_mask(la)) == 64'd0;
  endfunction

  logic [1:0] r;
  logic [2:0] c;
  assign r = cur.replica;
  assign c = cur.channel;

  logic eq_c;
  assign eq_c = (nact < 2'd2 || cnt[1][c] == cnt[0][c]) &&
                (nact < 2'd3 || cnt[2][c] == cnt[0][c]);
  logic a01, a12, a20, a02, a10, a21;
  assign a01 = agree_f(sw[0][c], sw[1][c], sl[0][c]);
  assign a12 = agree_f(sw[1][c], sw[2][c], sl[1][c]);
  assign a20 = agree_f(sw[2][c], sw[0][c], sl[2][c]);
  assign a02 = agree_f(sw[0][c], sw[2][c], sl[0][c]);
  assign a10 = agree_f(sw[1][c], sw[0][c], sl[1][c]);
  assign a21 = agree_f(sw[2][c], sw[1][c], sl[2][c]);

  // Pick the first agreeing pair, its dissenter and whether all three agree
  logic       pair_ok, all_ok;
  logic [1:0] vi, vk;
  assign pair_ok = a01 || a12 || a20;
  assign vi      = a01 ? 2'd0 : (a12 ? 2'd1 : 2'd2);
  assign vk      = a01 ? 2'd2 : (a12 ? 2'd0 : 2'd1);
  assign all_ok  = a01 ? a02 : (a12 ? a10 : a21);

  // Channels the restart walk sends; later channels are untouched by the walk
  logic [CHANNELS-1:0] hit_vec;
  logic                walk_hit, more_hits;
  always_comb begin
    for (int j = 0; j < CHANNELS; j++)
      hit_vec[j] = (CH_W'(j) == c) ||
        (cnt[1][j] == cnt[0][j] && cnt[2][j] == cnt[0][j] && cnt[0][j] >= 4'sd1);
  end
  assign walk_hit  = hit_vec[wch];
  assign more_hits = |((hit_vec >> wch) >> 1);
  assign ch_last   = (wch == CH_W'(CHANNELS - 1));

  // Build the result for the current step
  always_comb begin
    emit = 1'b0;
    res  = '0;
    case (state)
      S_VOTE: begin
        if (fwd_pend) begin
          emit = can_emit;
          res  = '{channel: c, word: fwd_word, bytes: fwd_len, kind: KIND_FWD,
                   mismatch: 1'b0, restart_valid: 1'b0, restart_replica: 2'd0,
                   last: !eq_c};
        end else if (eq_c) begin
          if (nact != 2'd3) begin
            emit = can_emit;
            res  = '{channel: c, word: sw[0][c], bytes: sl[0][c], kind: KIND_SEND,
                     mismatch: (nact == 2'd2) && !a01, restart_valid: 1'b0,
                     restart_replica: 2'd0, last: 1'b1};
          end else if (pair_ok) begin
            emit = can_emit && all_ok;
            res  = '{channel: c, word: sw[vi][c], bytes: sl[vi][c], kind: KIND_SEND,
                     mismatch: 1'b0, restart_valid: 1'b0, restart_replica: 2'd0,
                     last: 1'b1};
          end else begin
            emit = can_emit;
            res  = '{channel: c, word: 64'd0, bytes: 4'd0, kind: KIND_ALERT,
                     mismatch: 1'b0, restart_valid: 1'b0, restart_replica: 2'd0,
                     last: 1'b1};
          end
        end
      end
      S_WALK: begin
        emit = can_emit && walk_hit;
        res  = '{channel: wch, word: sw[pi][wch], bytes: sl[pi][wch], kind: KIND_SEND,
                 mismatch: 1'b0, restart_valid: first,
                 restart_replica: first ? pk : 2'd0, last: !more_hits};
      end
      default: ;
    endcase
  end

  // Load the output register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_res <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fwd_pend <= 1'b0;
      for (int i = 0; i < REPLICAS; i++)
        for (int j = 0; j < CHANNELS; j++) begin
          cnt[i][j] <= '0; sw[i][j] <= '0; sl[i][j] <= '0;
        end
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_item;
            state <= S_FWD;
          end
        end
        // Latch the old pending word, if this replica has one, and drop the active counts on its channel
        S_FWD: begin
          if (nact > 2'd1 && cnt[r][c] >= 4'sd1) begin
            fwd_pend <= 1'b1;
            fwd_word <= sw[r][c];
            fwd_len  <= sl[r][c];
            for (int i = 0; i < REPLICAS; i++)
              if (2'(i) < nact && cnt[i][c] != -4'sd8) cnt[i][c] <= cnt[i][c] - 4'sd1;
          end else fwd_pend <= 1'b0;
          state <= S_STORE;
        end
        // Store the new word and bump the sender's count
        S_STORE: begin
          sw[r][c] <= cur.word;
          sl[r][c] <= cur.bytes;
          if (cnt[r][c] != 4'sd7) cnt[r][c] <= cnt[r][c] + 4'sd1;
          state <= S_VOTE;
        end
        // Send the forward first, then vote
        S_VOTE: begin
          if (fwd_pend) begin
            if (can_emit) begin
              fwd_pend <= 1'b0;
              if (!eq_c) state <= S_IDLE;
            end
          end else if (!eq_c) begin
            state <= S_IDLE;
          end else if (can_emit) begin
            if (nact != 2'd3) begin
              for (int i = 0; i < REPLICAS; i++)
                if (2'(i) < nact && cnt[i][c] != -4'sd8) cnt[i][c] <= cnt[i][c] - 4'sd1;
              state <= S_IDLE;
            end else if (pair_ok) begin
              pi <= vi;
              pk <= vk;
              if (all_ok) begin
                for (int i = 0; i < REPLICAS; i++)
                  if (cnt[i][c] != -4'sd8) cnt[i][c] <= cnt[i][c] - 4'sd1;
                state <= S_IDLE;
              end else state <= S_COPY;
            end else state <= S_IDLE;
          end
        end
        // Copy the pair member into the dissenter, all channels at once
        S_COPY: begin
          for (int j = 0; j < CHANNELS; j++) begin
            cnt[pk][j] <= cnt[pi][j];
            sw[pk][j]  <= sw[pi][j];
            sl[pk][j]  <= sl[pi][j];
          end
          wch <= '0;
          first <= 1'b1;
          state <= S_WALK;
        end
        // Walk channels and send each complete vote
        S_WALK: begin
          if (walk_hit) begin
            if (can_emit) begin
              for (int i = 0; i < REPLICAS; i++)
                if (cnt[i][wch] != -4'sd8) cnt[i][wch] <= cnt[i][wch] - 4'sd1;
              first <= 1'b0;
              if (!more_hits) state <= S_IDLE;
              else wch <= wch + 1'b1;
            end
          end else if (ch_last) begin
            state <= S_IDLE;
          end else wch <= wch + 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("pop outside idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> pi != pk)
    else $error("restart pair collapsed");
endmodule

/* tb/sv/tmv_checker.sv */
// Checker for the message voter: predicts results from accepted words and compares.
// Watches the config port and both channels of tmr_message_voter; uses tmv_pkg.
module tmv_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  source_replica,
  input  logic [2:0]  channel,
  input  logic [63:0] message_word,
  input  logic [3:0]  message_bytes,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_channel,
  input  logic [63:0] out_word,
  input  logic [3:0]  out_bytes,
  input  logic [1:0]  out_kind,
  input  logic        mismatch,
  input  logic        restart_valid,
  input  logic [1:0]  restart_replica,
  input  logic        last,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmv_pkg::*;

  localparam int MAX_OUT = 9;

  int          votes [REPLICAS][CHANNELS];
  logic [63:0] held_word [REPLICAS][CHANNELS];
  logic [3:0]  held_len [REPLICAS][CHANNELS];
  logic [1:0]  mode;
  result_t     expected_q[$];
  int          n_out;

  function automatic logic [63:0] len_mask(logic [3:0] len);
    if (len >= 8) return '1;
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  function automatic int active_replicas();
    int n;
    n = mode;
    if (n == 0) n = 1;
    if (n > REPLICAS) n = REPLICAS;
    return n;
  endfunction

  function automatic bit counts_match(int c, int nact);
    for (int r = 1; r < nact; r++)
      if (votes[r][c] != votes[0][c]) return 0;
    return 1;
  endfunction

  function automatic bit words_agree(int a, int b, int c);
    return ((held_word[a][c] ^ held_word[b][c]) & len_mask(held_len[a][c])) == '0;
  endfunction

  task automatic drop_counts(int c, int nact);
    for (int r = 0; r < nact; r++)
      if (votes[r][c] > -8) votes[r][c]--;
  endtask

  task automatic push_result(int ch, logic [63:0] w, logic [3:0] b, logic [1:0] kind,
                             bit mm, bit rv, int rr);
    result_t e;
    if (n_out >= MAX_OUT) return;
    e.channel = 3'(ch);
    e.word = w;
    e.bytes = b;
    e.kind = kind;
    e.mismatch = mm;
    e.restart_valid = rv;
    e.restart_replica = 2'(rr);
    e.last = 0;
    expected_q.push_back(e);
    n_out++;
  endtask

  // Work out the results one accepted word causes
  task automatic vote_word(int r, int c, logic [63:0] w, logic [3:0] b_in);
    int  nact, j, k;
    bit  done, first;
    logic [3:0] b;
    nact = active_replicas();
    n_out = 0;
    if (r >= nact || b_in == 0) return;
    b = (b_in > MSG_BYTES) ? 4'(MSG_BYTES) : b_in;
    // forward the pending word when this replica repeats
    if (nact > 1 && votes[r][c] >= 1) begin
      push_result(c, held_word[r][c], held_len[r][c], KIND_FWD, 0, 0, 0);
      drop_counts(c, nact);
    end
    held_word[r][c] = w & len_mask(b);
    held_len[r][c] = b;
    if (votes[r][c] < 7) votes[r][c]++;
    if (counts_match(c, nact)) begin
      if (nact == 1) begin
        push_result(c, held_word[0][c], held_len[0][c], KIND_SEND, 0, 0, 0);
        drop_counts(c, nact);
      end else if (nact == 2) begin
        push_result(c, held_word[0][c], held_len[0][c], KIND_SEND,
                    !words_agree(0, 1, c), 0, 0);
        drop_counts(c, nact);
      end else begin
        done = 0;
        for (int i = 0; i < 3 && !done; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          if (!words_agree(i, j, c)) continue;
          done = 1;
          if (words_agree(i, k, c)) begin
            push_result(c, held_word[i][c], held_len[i][c], KIND_SEND, 0, 0, 0);
            drop_counts(c, nact);
          end else begin
            // resync the dissenter, then walk the channels
            first = 1;
            for (int ch = 0; ch < CHANNELS; ch++) begin
              votes[k][ch] = votes[i][ch];
              held_word[k][ch] = held_word[i][ch];
              held_len[k][ch] = held_len[i][ch];
            end
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (ch == c || (counts_match(ch, nact) && votes[0][ch] >= 1)) begin
                push_result(ch, held_word[i][ch], held_len[i][ch], KIND_SEND, 0,
                            first, first ? k : 0);
                drop_counts(ch, nact);
                first = 0;
              end
            end
          end
        end
        if (!done) push_result(c, '0, '0, KIND_ALERT, 0, 0, 0);
      end
    end
    if (n_out > 0) expected_q[expected_q.size() - 1].last = 1;
  endtask

  assign pending = expected_q.size();

  // Compare results first, then predict from the word accepted on this edge
  always @(posedge clk) begin
    result_t e, got;
    if (rst) begin
      for (int r = 0; r < REPLICAS; r++)
        for (int c = 0; c < CHANNELS; c++) begin
          votes[r][c] = 0;
          held_word[r][c] = '0;
          held_len[r][c] = '0;
        end
      mode = 2'd3;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) mode = cfg_data;
      if (out_valid && out_ready) begin
        got = '{out_channel, out_word, out_bytes, out_kind, mismatch,
                restart_valid, restart_replica, last};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, got);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (e.channel !== got.channel || e.word !== got.word ||
              e.bytes !== got.bytes || e.kind !== got.kind ||
              e.mismatch !== got.mismatch || e.restart_valid !== got.restart_valid ||
              e.restart_replica !== got.restart_replica || e.last !== got.last) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, e, got);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        vote_word(source_replica, channel, message_word, message_bytes);
    end
  end
endmodule

/* tb/sv/tb.sv */
// Top of the message voter testbench: clock, reset, stimulus and verdict.
// Instantiates tmr_message_voter and tmv_checker; uses tmv_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tmv_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int SETTLE = 60;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  source_replica = 0;
  logic [2:0]  channel = 0;
  logic [63:0] message_word = 0;
  logic [3:0]  message_bytes = 1;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  out_channel;
  logic [63:0] out_word;
  logic [3:0]  out_bytes;
  logic [1:0]  out_kind;
  logic        mismatch, restart_valid, last;
  logic [1:0]  restart_replica;
  int          errors, pending;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_req = 0;
  int          quiet = 0;
  int          mode_now = 3;

  always #5 clk = ~clk;

  tmr_message_voter DUT (.*);
  tmv_checker u_checker (.*);

  // Receiver: random stalls plus one long hold-off in the last random phase
  initial begin
    int hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one word, with random idle gaps ahead of it
  task automatic send_word(logic [1:0] r, logic [2:0] c, logic [63:0] w, logic [3:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    source_replica <= r;
    channel <= c;
    message_word <= w;
    message_bytes <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drain, let a possible restart walk finish, then write the mode
  task automatic set_mode(logic [1:0] m);
    in_valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1;
    cfg_data <= m;
    mode_now = m;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_all(logic [2:0] c, logic [63:0] w, logic [3:0] b);
    for (int r = 0; r < 3; r++) send_word(2'(r), c, w, b);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Random group: every active replica sends one channel, some corrupted
  task automatic send_group();
    int nact, c, b, a, t;
    int order[3];
    logic [63:0] w;
    nact = (mode_now == 0) ? 1 : mode_now;
    c = $urandom_range(7);
    w = rand_word();
    b = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
    order = '{0, 1, 2};
    for (int i = nact - 1; i > 0; i--) begin
      a = $urandom_range(i);
      t = order[i];
      order[i] = order[a];
      order[a] = t;
    end
    for (int i = 0; i < nact; i++) begin
      if ($urandom_range(99) < 15) send_word(2'(order[i]), 3'(c), w ^ rand_word(), 4'(b));
      else send_word(2'(order[i]), 3'(c), w, 4'(b));
    end
  endtask

  initial begin
    int sent, pct_a[4], pct_b[4];
    logic [1:0] modes[5];
    pct_a = '{0, 73, 0, 31};
    pct_b = '{0, 0, 73, 31};
    modes = '{2'd3, 2'd2, 2'd1, 2'd0, 2'd3};
    repeat (10) @(negedge clk);
    rst <= 0;
    set_mode(2'd3);

    // Directed: agree, dissent with restart walk, no majority, forwards, edge fields
    send_all(3'd0, '1, 4'd8);
    send_all(3'd7, '0, 4'd1);
    send_word(2'd0, 3'd2, 64'h1111, 4'd2);
    send_word(2'd1, 3'd2, 64'h1111, 4'd2);
    send_word(2'd2, 3'd2, 64'h2222, 4'd2);
    send_word(2'd0, 3'd3, 64'h01, 4'd1);
    send_word(2'd1, 3'd3, 64'h02, 4'd1);
    send_word(2'd2, 3'd3, 64'h03, 4'd1);
    send_word(2'd0, 3'd4, 64'hAA00_0055, 4'd1);
    send_word(2'd1, 3'd4, 64'hBB00_0055, 4'd1);
    send_word(2'd2, 3'd4, 64'h5555_5555_5555_5555, 4'd15);
    send_word(2'd0, 3'd5, 64'h5, 4'd0);
    send_word(2'd3, 3'd5, 64'h5, 4'd3);
    send_word(2'd1, 3'd6, '1, 4'd8);
    send_word(2'd1, 3'd6, 64'h3, 4'd8);
    send_word(2'd2, 3'd6, 64'h3, 4'd8);
    send_word(2'd0, 3'd6, 64'h3, 4'd8);

    // Random phases over several modes and idle settings
    sent = 0;
    for (int p = 0; p < 5; p++) begin
      set_mode(modes[p]);
      send_idle_pct = pct_a[p % 4];
      stall_pct = pct_b[p % 4];
      if (p == 4) hold_req++;
      for (int i = 0; i < 200; i++) begin
        if ($urandom_range(9) == 0) begin
          send_word(2'($urandom_range(3)), 3'($urandom_range(7)), rand_word(),
                    4'($urandom_range(15)));
          sent++;
        end else begin
          send_group();
          sent += (mode_now == 0) ? 1 : mode_now;
        end
        if (sent >= 90 * (p + 1)) break;
      end
    end
    in_valid <= 0;
    stall_pct = 0;

    // Drain and settle
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
